>>> sv/rmsm_pkg.sv
// ---------------------------------------------------------------------------
// rmsm_pkg : shared types and constants for the row maze set merger
// Word layouts for the input and result channels, sizes and widths.
// ---------------------------------------------------------------------------
package rmsm_pkg;

    localparam int MAX_SIZE_DEF = 32;
    localparam int SIZE_W       = 6;
    localparam int ROW_W        = 5;
    localparam int FIELD_COLS   = 32;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef struct packed {
        logic [30:0] merge_request;
        logic [31:0] drop_request;
    } in_word_t;

    typedef struct packed {
        logic [30:0] right_open;
        logic [31:0] down_open;
        logic [4:0]  row_number;
        logic        last_row;
    } out_word_t;

    // command broadcast from the sequencer to every column cell
    typedef struct packed {
        logic load_init;   // return label to own index
        logic merge_en;    // relabel from -> to
        logic drop_en;     // drop phase step
        logic seen_clr;    // clear seen flag
        logic renum_en;    // renumber phase step
        logic commit;      // take renumbered label
    } cell_cmd_t;

endpackage

>>> sv/rmsm_cell.sv
// ---------------------------------------------------------------------------
// rmsm_cell : one column of the set label row
// Holds the column's label and the renumbered label and done flag of the
// renumber pass. Broadcast compares do the relabelling.
// ---------------------------------------------------------------------------
module rmsm_cell #(
    parameter int LW  = 5,
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rmsm_pkg::cell_cmd_t cmd,
    input  logic [LW-1:0]     from_lab,
    input  logic [LW-1:0]     to_lab,
    input  logic              renum_hit,
    output logic [LW-1:0]     label
);

    logic [LW-1:0] label_reg, label_next;
    logic [LW-1:0] new_reg,   new_next;
    logic          done_reg,  done_next;

    // relabel on merge broadcast; renumber takes first matching column
    always_comb
    begin
        label_next = label_reg;
        new_next   = new_reg;
        done_next  = done_reg;
        if (cmd.load_init)
        begin
            label_next = LW'(IDX);
        end
        else if (cmd.merge_en && label_reg == from_lab)
        begin
            label_next = to_lab;
        end
        if (cmd.seen_clr)
        begin
            new_next  = LW'(IDX);
            done_next = 1'b0;
        end
        else if (cmd.renum_en && renum_hit && !done_reg)
        begin
            new_next  = to_lab;
            done_next = 1'b1;
        end
        if (cmd.commit)
        begin
            label_next = new_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= LW'(IDX);
            done_reg  <= 1'b0;
        end
        else
        begin
            label_reg <= label_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
    end

    assign label = label_reg;

endmodule

>>> sv/row_maze_set_merger.sv
// ---------------------------------------------------------------------------
// row_maze_set_merger : Eller's maze generator, one row per input word
// Row of column cells holding set labels, driven by a step sequencer.
// ---------------------------------------------------------------------------
// channel   dir  handshake       payload
// in        in   in_valid/stall  merge_request, drop_request
// out       out  out_valid/stall right_open, down_open, row_number, last_row
// cfg       in   cfg_valid/ready maze_size
//
// A row takes n-1 merge steps, n drop steps, n renumber steps, a finish
// step, an output step and the idle step that takes the next word; a last
// row skips the drop and renumber passes. The sequencer visits one column
// per cycle. The output register frees the engine, so the next word is
// taken while a result waits; the output step stalls only while the previous
// result is still held. Reset gives labels = column index, left to right
// scan, row zero.
// ---------------------------------------------------------------------------
module row_maze_set_merger #(
    parameter int MAX_SIZE = rmsm_pkg::MAX_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rmsm_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rmsm_pkg::out_word_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [rmsm_pkg::SIZE_W-1:0] cfg_data
);

    localparam int NC = (MAX_SIZE < rmsm_pkg::FIELD_COLS) ? MAX_SIZE : rmsm_pkg::FIELD_COLS;
    localparam int LW = 5;
    localparam int KW = 6;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MERGE = 3'd1;
    localparam logic [2:0] ST_DROP  = 3'd2;
    localparam logic [2:0] ST_REN   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [rmsm_pkg::SIZE_W-1:0] size_reg;
    logic [2:0]  st_reg, st_next;
    logic [KW-1:0] k_reg, k_next;
    logic        scan_reg, scan_next;
    logic [4:0]  row_reg, row_next;
    logic [4:0]  rnum_reg, rnum_next;
    logic        last_reg, last_next;
    logic [30:0] mreq_reg, mreq_next, right_reg, right_next;
    logic [31:0] dreq_reg, dreq_next, down_reg, down_next;
    logic [31:0] seen_reg, seen_next;
    logic        ov_reg;
    rmsm_pkg::out_word_t od_reg;

    logic [LW-1:0] labels [NC];
    logic [LW-1:0] from_lab, to_lab;
    logic [NC-1:0] renum_hit;
    rmsm_pkg::cell_cmd_t cmd;
    logic [KW-1:0] n;
    logic [4:0]  col;
    logic        in_acc, done;

    // clamp configured size
    always_comb
    begin
        if (size_reg < 6'd2)
            n = 6'd2;
        else if (size_reg > KW'(NC))
            n = KW'(NC);
        else
            n = size_reg;
    end

    assign in_stall  = (st_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // column visited this step; renumbering always runs left to right
    always_comb
    begin
        if (st_reg == ST_MERGE)
            col = scan_reg ? k_reg[4:0] : 5'(n - 6'd2 - k_reg);
        else if (st_reg == ST_REN)
            col = k_reg[4:0];
        else
            col = scan_reg ? k_reg[4:0] : 5'(n - 6'd1 - k_reg);
    end

    // label lookup for the current column and its right neighbour
    logic [LW-1:0] lab_c, lab_c1;
    always_comb
    begin
        lab_c  = labels[col[$clog2(NC)-1:0]];
        lab_c1 = (32'(col) + 1 < NC) ? labels[$clog2(NC)'(32'(col) + 1)] : lab_c;
    end

    logic merge_do, drop_do;
    assign merge_do = (last_reg || mreq_reg[col]) && (lab_c != lab_c1);
    assign drop_do  = dreq_reg[col] || !seen_reg[lab_c];

    // renumber: column k (left to right) is leader for later kept columns
    logic kept_k;
    assign kept_k = down_reg[k_reg[4:0]];
    generate
        for (genvar i = 0; i < NC; i++)
        begin : g_hit
            assign renum_hit[i] = kept_k && down_reg[i] && (32'(k_reg) <= i)
                                  && (labels[i] == lab_c);
        end
    endgenerate

    always_comb
    begin
        from_lab = lab_c1;
        to_lab   = (st_reg == ST_REN) ? LW'(k_reg) : lab_c;
        cmd      = '0;
        cmd.merge_en  = (st_reg == ST_MERGE) && merge_do;
        cmd.seen_clr  = in_acc;
        cmd.renum_en  = (st_reg == ST_REN);
        cmd.commit    = (st_reg == ST_FIN) && !last_reg;
        cmd.load_init = (st_reg == ST_FIN) && last_reg;
        cmd.drop_en   = (st_reg == ST_DROP);
    end

    generate
        for (genvar i = 0; i < NC; i++)
        begin : g_cell
            rmsm_cell #(.LW(LW), .IDX(i)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .from_lab (from_lab),
                .to_lab   (to_lab),
                .renum_hit(renum_hit[i]),
                .label    (labels[i])
            );
        end
    endgenerate

    // step sequencer
    assign done = (ov_reg && out_stall);
    always_comb
    begin
        st_next = st_reg; k_next = k_reg; scan_next = scan_reg; row_next = row_reg;
        last_next = last_reg; mreq_next = mreq_reg; dreq_next = dreq_reg;
        right_next = right_reg; down_next = down_reg; seen_next = seen_reg;
        rnum_next = rnum_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    mreq_next  = in_data.merge_request;
                    dreq_next  = in_data.drop_request;
                    last_next  = (6'(row_reg) >= n - 6'd1);
                    rnum_next  = row_reg;
                    right_next = '0;
                    down_next  = '0;
                    seen_next  = '0;
                    k_next     = '0;
                    st_next    = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (merge_do)
                    right_next[col] = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg == n - 6'd2)
                begin
                    k_next  = '0;
                    st_next = last_reg ? ST_FIN : ST_DROP;
                end
            end
            ST_DROP:
            begin
                if (drop_do)
                begin
                    down_next[col]  = 1'b1;
                    seen_next[lab_c] = 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == n - 6'd1)
                begin
                    k_next  = '0;
                    st_next = ST_REN;
                end
            end
            ST_REN:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == n - 6'd1)
                    st_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (last_reg)
                    row_next = '0;
                else
                begin
                    row_next  = row_reg + 1'b1;
                    scan_next = !scan_reg;
                end
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!done)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            k_reg    <= '0;
            scan_reg <= 1'b1;
            row_reg  <= '0;
            size_reg <= rmsm_pkg::SIZE_RESET;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            k_reg    <= k_next;
            scan_reg <= scan_next;
            row_reg  <= row_next;
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            if (st_reg == ST_OUT && !done)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    // working payload and output word
    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        mreq_reg  <= mreq_next;
        dreq_reg  <= dreq_next;
        right_reg <= right_next;
        down_reg  <= down_next;
        seen_reg  <= seen_next;
        rnum_reg  <= rnum_next;
        if (st_reg == ST_OUT && !done)
        begin
            od_reg.right_open <= right_reg;
            od_reg.down_open  <= down_reg;
            od_reg.row_number <= rnum_reg;
            od_reg.last_row   <= last_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

`ifndef SYNTHESIS
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> in_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DROP) |-> (k_reg < n)) else $error("column index overrun");
`endif

endmodule
